FILE: design/qapc_pkg.sv
// Shared types, widths and register codes for the quaternion attitude P controller.
// No dependencies; imported by qapc_axis and quaternion_attitude_p_controller.
package qapc_pkg;

	// Field widths
	localparam int QUAT_WIDTH = 16;
	localparam int RATE_WIDTH = 24;
	localparam int GAIN_WIDTH = 16;
	localparam int LIM_WIDTH  = RATE_WIDTH - 1;
	localparam int CFG_WIDTH  = (LIM_WIDTH > GAIN_WIDTH) ? LIM_WIDTH : GAIN_WIDTH;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int NUM_AXES   = 3;

	// Quaternion product scaling: wide inputs are brought back to 32 bits
	localparam int PROD_SHIFT = (QUAT_WIDTH > 16) ? (2 * QUAT_WIDTH - 32) : 0;
	localparam int PROD_WIDTH = 2 * QUAT_WIDTH - PROD_SHIFT;
	localparam int ERR_WIDTH  = PROD_WIDTH + 2;
	localparam int ERR_FRAC   = 2 * (QUAT_WIDTH - 2) - PROD_SHIFT;

	// Rate = |err| * gain * 2, rescaled to 12 fraction bits
	localparam int RATE_FRAC    = 12;
	localparam int RATE_SHIFT   = ERR_FRAC + 8 - 1 - RATE_FRAC;
	localparam int SCALED_WIDTH = ERR_WIDTH + GAIN_WIDTH;
	localparam int MAG_WIDTH    = SCALED_WIDTH - RATE_SHIFT;
	localparam int CMP_WIDTH    = ((MAG_WIDTH > RATE_WIDTH) ? MAG_WIDTH : RATE_WIDTH) + 1;

	// Cycles from accepted start to done
	localparam int LATENCY = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ROLL_GAIN   = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ROLL_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PITCH_GAIN  = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PITCH_LIMIT = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_YAW_GAIN    = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_YAW_LIMIT   = 3'd5;

	localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(256);

	// Input item: setpoint and measured quaternions
	typedef struct packed {
		logic signed [QUAT_WIDTH-1:0] target_w;
		logic signed [QUAT_WIDTH-1:0] target_x;
		logic signed [QUAT_WIDTH-1:0] target_y;
		logic signed [QUAT_WIDTH-1:0] target_z;
		logic signed [QUAT_WIDTH-1:0] sensed_w;
		logic signed [QUAT_WIDTH-1:0] sensed_x;
		logic signed [QUAT_WIDTH-1:0] sensed_y;
		logic signed [QUAT_WIDTH-1:0] sensed_z;
	} req_t;

	// Result item: body rate commands
	typedef struct packed {
		logic signed [RATE_WIDTH-1:0] roll_rate_cmd;
		logic signed [RATE_WIDTH-1:0] pitch_rate_cmd;
		logic signed [RATE_WIDTH-1:0] yaw_rate_cmd;
	} result_t;

	// Signed component product, floor-shifted to PROD_WIDTH bits
	function automatic logic signed [PROD_WIDTH-1:0] qmul(
		input logic signed [QUAT_WIDTH-1:0] a,
		input logic signed [QUAT_WIDTH-1:0] b
	);
		logic signed [2*QUAT_WIDTH-1:0] full;
		logic signed [2*QUAT_WIDTH-1:0] shifted;
		full    = a * b;
		shifted = full >>> PROD_SHIFT;
		return shifted[PROD_WIDTH-1:0];
	endfunction

endpackage

FILE: design/qapc_axis.sv
// One axis of the rate path: short-arc sign fix, gain multiply, clamp and saturate.
// Depends on qapc_pkg. Three register stages (s3, s4, s5 of the top-level pipeline).
module qapc_axis (
	input  logic                                  clk,
	input  logic signed [qapc_pkg::ERR_WIDTH-1:0] err,
	input  logic                                  flip,
	input  logic        [qapc_pkg::GAIN_WIDTH-1:0] gain,
	input  logic        [qapc_pkg::LIM_WIDTH-1:0]  limit,
	output logic signed [qapc_pkg::RATE_WIDTH-1:0] rate
);
	import qapc_pkg::*;

	logic                    neg_s3;
	logic [ERR_WIDTH-1:0]    mag_s3;
	logic                    neg_s4;
	logic [SCALED_WIDTH-1:0] scaled_s4;
	logic signed [RATE_WIDTH-1:0] rate_s5;

	logic                 err_neg;
	logic                 err_pos;
	logic [CMP_WIDTH-1:0] mag;
	logic [CMP_WIDTH-1:0] lim_ext;
	logic [CMP_WIDTH-1:0] cap;
	logic [CMP_WIDTH-1:0] mag_lim;
	logic [CMP_WIDTH-1:0] mag_sat;
	logic [CMP_WIDTH-1:0] signed_res;

	// s3: sign of the flipped error and its magnitude
	assign err_neg = err[ERR_WIDTH-1];
	assign err_pos = !err_neg && (err != '0);

	always_ff @(posedge clk) begin
		neg_s3 <= flip ? err_pos : err_neg;
		mag_s3 <= err_neg ? (ERR_WIDTH'(0) - err) : err;
	end

	// s4: magnitude times gain
	always_ff @(posedge clk) begin
		neg_s4    <= neg_s3;
		scaled_s4 <= SCALED_WIDTH'(mag_s3) * SCALED_WIDTH'(gain);
	end

	// s5: rescale, limit clamp, field saturation, restore sign
	always_comb begin
		mag     = CMP_WIDTH'(scaled_s4 >> RATE_SHIFT);
		lim_ext = CMP_WIDTH'(limit);
		cap     = neg_s4 ? (CMP_WIDTH'(1) << (RATE_WIDTH - 1))
		                 : ((CMP_WIDTH'(1) << (RATE_WIDTH - 1)) - CMP_WIDTH'(1));
		mag_lim = ((lim_ext != '0) && (mag > lim_ext)) ? lim_ext : mag;
		mag_sat = (mag_lim > cap) ? cap : mag_lim;
		signed_res = neg_s4 ? (CMP_WIDTH'(0) - mag_sat) : mag_sat;
	end

	always_ff @(posedge clk) begin
		rate_s5 <= signed_res[RATE_WIDTH-1:0];
	end

	assign rate = rate_s5;

endmodule

FILE: design/quaternion_attitude_p_controller.sv
// Quaternion attitude proportional controller, top level.
// Depends on qapc_pkg and qapc_axis.
//
// Takes one quaternion pair per clock: a transfer happens on any cycle with start high
// (busy is always low). A result appears on result, marked by a one-cycle done strobe;
// the receiver cannot stall it, so results must be taken as they come. Each item passes
// through the five-stage pipeline: the sixteen component products, the four-term error
// sums, the short-arc sign fix, the gain multiply, and the clamp stage. Configuration
// writes take effect on the next cycle and should only be issued with no items
// in flight.
module quaternion_attitude_p_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  qapc_pkg::req_t                        req,
	output logic                                  done,
	output qapc_pkg::result_t                     result,
	input  logic                                  cfg_we,
	input  logic [qapc_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx,
	input  logic [qapc_pkg::CFG_WIDTH-1:0]        cfg_data
);
	import qapc_pkg::*;

	// Configuration registers, one per axis
	logic [GAIN_WIDTH-1:0] gain_q [NUM_AXES];
	logic [LIM_WIDTH-1:0]  lim_q  [NUM_AXES];

	// Valid bits travel with the data
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// s1 products: row 0 for the scalar part, rows 1..3 for x, y, z
	logic signed [PROD_WIDTH-1:0] prod_s1 [4][4];
	// s2 error quaternion
	logic signed [ERR_WIDTH-1:0]  err_s2 [NUM_AXES];
	logic                         flip_s2;

	logic signed [ERR_WIDTH-1:0]  ew_sum;
	logic signed [ERR_WIDTH-1:0]  ev_sum [NUM_AXES];
	logic signed [RATE_WIDTH-1:0] rate [NUM_AXES];

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				gain_q[i] <= GAIN_RESET;
				lim_q[i]  <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ROLL_GAIN:   gain_q[0] <= cfg_data[GAIN_WIDTH-1:0];
				REG_ROLL_LIMIT:  lim_q[0]  <= cfg_data[LIM_WIDTH-1:0];
				REG_PITCH_GAIN:  gain_q[1] <= cfg_data[GAIN_WIDTH-1:0];
				REG_PITCH_LIMIT: lim_q[1]  <= cfg_data[LIM_WIDTH-1:0];
				REG_YAW_GAIN:    gain_q[2] <= cfg_data[GAIN_WIDTH-1:0];
				REG_YAW_LIMIT:   lim_q[2]  <= cfg_data[LIM_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// s1: products of conjugate(measured) * setpoint
	always_ff @(posedge clk) begin
		prod_s1[0][0] <= qmul(req.sensed_w, req.target_w);
		prod_s1[0][1] <= qmul(req.sensed_x, req.target_x);
		prod_s1[0][2] <= qmul(req.sensed_y, req.target_y);
		prod_s1[0][3] <= qmul(req.sensed_z, req.target_z);

		prod_s1[1][0] <= qmul(req.sensed_w, req.target_x);
		prod_s1[1][1] <= qmul(req.target_w, req.sensed_x);
		prod_s1[1][2] <= qmul(req.sensed_y, req.target_z);
		prod_s1[1][3] <= qmul(req.sensed_z, req.target_y);

		prod_s1[2][0] <= qmul(req.sensed_w, req.target_y);
		prod_s1[2][1] <= qmul(req.target_w, req.sensed_y);
		prod_s1[2][2] <= qmul(req.sensed_z, req.target_x);
		prod_s1[2][3] <= qmul(req.sensed_x, req.target_z);

		prod_s1[3][0] <= qmul(req.sensed_w, req.target_z);
		prod_s1[3][1] <= qmul(req.target_w, req.sensed_z);
		prod_s1[3][2] <= qmul(req.sensed_x, req.target_y);
		prod_s1[3][3] <= qmul(req.sensed_y, req.target_x);
	end

	// s2: four-term sums; vector terms all follow + - - +
	always_comb begin
		ew_sum = ERR_WIDTH'(prod_s1[0][0]) + ERR_WIDTH'(prod_s1[0][1])
		       + ERR_WIDTH'(prod_s1[0][2]) + ERR_WIDTH'(prod_s1[0][3]);
		for (int a = 0; a < NUM_AXES; a++) begin
			ev_sum[a] = ERR_WIDTH'(prod_s1[a+1][0]) - ERR_WIDTH'(prod_s1[a+1][1])
			          - ERR_WIDTH'(prod_s1[a+1][2]) + ERR_WIDTH'(prod_s1[a+1][3]);
		end
	end

	always_ff @(posedge clk) begin
		flip_s2 <= ew_sum[ERR_WIDTH-1];
		for (int a = 0; a < NUM_AXES; a++) begin
			err_s2[a] <= ev_sum[a];
		end
	end

	// s3..s5: per-axis rate path
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		qapc_axis u_axis (
			.clk   (clk),
			.err   (err_s2[a]),
			.flip  (flip_s2),
			.gain  (gain_q[a]),
			.limit (lim_q[a]),
			.rate  (rate[a])
		);
	end

	assign done                  = valid_s5;
	assign result.roll_rate_cmd  = rate[0];
	assign result.pitch_rate_cmd = rate[1];
	assign result.yaw_rate_cmd   = rate[2];

	// Every accepted transfer is followed by its done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("result missing after accepted transfer");

	// Nonzero roll limit bounds the roll command
	a_roll_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (lim_q[0] != '0)) |->
			(($signed(result.roll_rate_cmd) <= $signed({1'b0, lim_q[0]})) &&
			 ($signed(result.roll_rate_cmd) >= -$signed({1'b0, lim_q[0]}))))
		else $error("roll command exceeds its limit");

	// Nonzero yaw limit bounds the yaw command
	a_yaw_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (lim_q[2] != '0)) |->
			(($signed(result.yaw_rate_cmd) <= $signed({1'b0, lim_q[2]})) &&
			 ($signed(result.yaw_rate_cmd) >= -$signed({1'b0, lim_q[2]}))))
		else $error("yaw command exceeds its limit");

endmodule

FILE: bench/quaternion_attitude_p_controller_test.sv
// Self-checking testbench for quaternion_attitude_p_controller: directed rows, then random
// quaternion pairs over several gain and limit settings, each result checked in order.
// Depends on qapc_pkg and the controller RTL only.
module quaternion_attitude_p_controller_test;
	import qapc_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 10;
	localparam int DIR_ROWS       = 15;
	localparam int PHASES         = 8;

	// indexes past the last register, which the block must ignore
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		req_t    pair;
		logic    fixed;
		result_t rates;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	req_t                     pair_in;
	logic                     done;
	result_t                  rates_out;
	logic                     cfg_we;
	logic [CFG_IDX_WIDTH-1:0] cfg_idx;
	logic [CFG_WIDTH-1:0]     cfg_data;

	// typed-in expectation riding along with the current transfer
	logic    fixed_valid;
	result_t fixed_rates;

	// shadow registers and expected rate commands
	logic [GAIN_WIDTH-1:0] gain_reg  [NUM_AXES];
	logic [LIM_WIDTH-1:0]  limit_reg [NUM_AXES];
	result_t               pending_rates [$];
	result_t               oldest_rates;

	int       failures;
	int       idle_cycles;
	bit       idling_on;
	dir_row_t directed [DIR_ROWS];

	quaternion_attitude_p_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (pair_in),
		.done     (done),
		.result   (rates_out),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	// full-precision component product, floor-scaled for wide quaternions
	function automatic longint component_product(longint a, longint b);
		return (a * b) >>> PROD_SHIFT;
	endfunction

	// gain, truncate toward zero, clamp to limit, then to the field range
	function automatic logic signed [RATE_WIDTH-1:0] axis_command(longint err,
			logic [GAIN_WIDTH-1:0] gain, logic [LIM_WIDTH-1:0] lim);
		longint mag;
		longint r;
		longint hi;
		longint lo;
		hi  = (longint'(1) <<< (RATE_WIDTH - 1)) - 1;
		lo  = -hi - 1;
		mag = (err < 0) ? -err : err;
		r   = (mag * longint'(gain)) >>> RATE_SHIFT;
		if (err < 0)
			r = -r;
		if (lim != '0) begin
			if (r > longint'(lim))
				r = longint'(lim);
			if (r < -longint'(lim))
				r = -longint'(lim);
		end
		if (r > hi)
			r = hi;
		if (r < lo)
			r = lo;
		return r[RATE_WIDTH-1:0];
	endfunction

	// error = conj(sensed) * target, short arc, then per-axis rate
	function automatic result_t attitude_rates(req_t q);
		longint tw, tx, ty, tz, sw, sx, sy, sz;
		longint ew, ex, ey, ez;
		result_t r;
		tw = longint'($signed(q.target_w));
		tx = longint'($signed(q.target_x));
		ty = longint'($signed(q.target_y));
		tz = longint'($signed(q.target_z));
		sw = longint'($signed(q.sensed_w));
		sx = longint'($signed(q.sensed_x));
		sy = longint'($signed(q.sensed_y));
		sz = longint'($signed(q.sensed_z));
		ew = component_product(sw, tw) + component_product(sx, tx)
			+ component_product(sy, ty) + component_product(sz, tz);
		ex = component_product(sw, tx) - component_product(tw, sx)
			- component_product(sy, tz) + component_product(sz, ty);
		ey = component_product(sw, ty) - component_product(tw, sy)
			- component_product(sz, tx) + component_product(sx, tz);
		ez = component_product(sw, tz) - component_product(tw, sz)
			- component_product(sx, ty) + component_product(sy, tx);
		// zero scalar part keeps its sign
		if (ew < 0) begin
			ex = -ex;
			ey = -ey;
			ez = -ez;
		end
		r.roll_rate_cmd  = axis_command(ex, gain_reg[0], limit_reg[0]);
		r.pitch_rate_cmd = axis_command(ey, gain_reg[1], limit_reg[1]);
		r.yaw_rate_cmd   = axis_command(ez, gain_reg[2], limit_reg[2]);
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_failure(input string msg);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, msg);
	endtask

	task automatic compare_field(input string axis_name,
			input logic signed [RATE_WIDTH-1:0] want, input logic signed [RATE_WIDTH-1:0] got);
		if (got !== want)
			report_failure($sformatf("%s rate: expected %0d, got %0d", axis_name, want, got));
	endtask

	// shadow register writes, accepted transfers and arriving results
	always @(posedge clk) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				gain_reg[a]  = GAIN_RESET;
				limit_reg[a] = '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ROLL_GAIN:   gain_reg[0]  = cfg_data[GAIN_WIDTH-1:0];
					REG_ROLL_LIMIT:  limit_reg[0] = cfg_data[LIM_WIDTH-1:0];
					REG_PITCH_GAIN:  gain_reg[1]  = cfg_data[GAIN_WIDTH-1:0];
					REG_PITCH_LIMIT: limit_reg[1] = cfg_data[LIM_WIDTH-1:0];
					REG_YAW_GAIN:    gain_reg[2]  = cfg_data[GAIN_WIDTH-1:0];
					REG_YAW_LIMIT:   limit_reg[2] = cfg_data[LIM_WIDTH-1:0];
					default: ;
				endcase
			end
			if (done === 1'b1) begin
				if (pending_rates.size() == 0) begin
					report_failure("result transfer with no expectation pending");
				end else begin
					oldest_rates = pending_rates.pop_front();
					compare_field("roll", oldest_rates.roll_rate_cmd, rates_out.roll_rate_cmd);
					compare_field("pitch", oldest_rates.pitch_rate_cmd,
						rates_out.pitch_rate_cmd);
					compare_field("yaw", oldest_rates.yaw_rate_cmd, rates_out.yaw_rate_cmd);
				end
			end
			if (start && !busy)
				pending_rates.push_back(fixed_valid ? fixed_rates : attitude_rates(pair_in));
		end
	end

	// stall detection: no transfer in either direction for too long
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic req_t quat_pair(int tw, int tx, int ty, int tz,
			int sw, int sx, int sy, int sz);
		req_t p;
		p.target_w = QUAT_WIDTH'(tw);
		p.target_x = QUAT_WIDTH'(tx);
		p.target_y = QUAT_WIDTH'(ty);
		p.target_z = QUAT_WIDTH'(tz);
		p.sensed_w = QUAT_WIDTH'(sw);
		p.sensed_x = QUAT_WIDTH'(sx);
		p.sensed_y = QUAT_WIDTH'(sy);
		p.sensed_z = QUAT_WIDTH'(sz);
		return p;
	endfunction

	function automatic dir_row_t stim_row(req_t p, logic f, int rr, int pr, int yr);
		dir_row_t d;
		d.pair                 = p;
		d.fixed                = f;
		d.rates.roll_rate_cmd  = RATE_WIDTH'(rr);
		d.rates.pitch_rate_cmd = RATE_WIDTH'(pr);
		d.rates.yaw_rate_cmd   = RATE_WIDTH'(yr);
		return d;
	endfunction

	function automatic logic [QUAT_WIDTH-1:0] rand_component();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0:       return QUAT_WIDTH'(-32768);
					1:       return QUAT_WIDTH'(32767);
					2:       return '0;
					3:       return QUAT_WIDTH'(16384);
					default: return QUAT_WIDTH'(-16384);
				endcase
			end
			1:       return QUAT_WIDTH'($urandom_range(0, 16000) - 8000);
			default: return QUAT_WIDTH'($urandom);
		endcase
	endfunction

	// mostly arbitrary pairs; a share track closely, as in closed-loop use
	function automatic req_t rand_pair();
		req_t p;
		p.target_w = rand_component();
		p.target_x = rand_component();
		p.target_y = rand_component();
		p.target_z = rand_component();
		if ($urandom_range(0, 3) == 0) begin
			p.sensed_w = p.target_w + QUAT_WIDTH'($urandom_range(0, 400) - 200);
			p.sensed_x = p.target_x + QUAT_WIDTH'($urandom_range(0, 400) - 200);
			p.sensed_y = p.target_y + QUAT_WIDTH'($urandom_range(0, 400) - 200);
			p.sensed_z = p.target_z + QUAT_WIDTH'($urandom_range(0, 400) - 200);
		end else begin
			p.sensed_w = rand_component();
			p.sensed_x = rand_component();
			p.sensed_y = rand_component();
			p.sensed_z = rand_component();
		end
		return p;
	endfunction

	function automatic logic [CFG_WIDTH-1:0] rand_limit();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return CFG_WIDTH'($urandom_range(1, 4096));
			2:       return CFG_WIDTH'($urandom_range(4096, 1 << 20));
			default: return CFG_WIDTH'($urandom);
		endcase
	endfunction

	// one transfer; start stays high on return so back-to-back items need no toggle
	task automatic send_pair(input req_t p, input logic f, input result_t fr);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		pair_in     = p;
		fixed_valid = f;
		fixed_rates = fr;
		start       = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off until every outstanding result has come back
	task automatic drain();
		start = 1'b0;
		while (pending_rates.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	task automatic program_axes(input logic [CFG_WIDTH-1:0] rg, input logic [CFG_WIDTH-1:0] rl,
			input logic [CFG_WIDTH-1:0] pg, input logic [CFG_WIDTH-1:0] pl,
			input logic [CFG_WIDTH-1:0] yg, input logic [CFG_WIDTH-1:0] yl);
		write_reg(REG_ROLL_GAIN, rg);
		write_reg(REG_ROLL_LIMIT, rl);
		write_reg(REG_PITCH_GAIN, pg);
		write_reg(REG_PITCH_LIMIT, pl);
		write_reg(REG_YAW_GAIN, yg);
		write_reg(REG_YAW_LIMIT, yl);
	endtask

	initial begin
		int count;
		arst_n      = 1'b0;
		start       = 1'b0;
		pair_in     = '0;
		cfg_we      = 1'b0;
		cfg_idx     = '0;
		cfg_data    = '0;
		fixed_valid = 1'b0;
		fixed_rates = '0;
		failures    = 0;
		idle_cycles = 0;
		idling_on   = 1'b1;

		// reset gains are 1.0 with no clamp: unit half-turns give 2.0 rad/s = 8192
		directed[0]  = stim_row(quat_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 0, 0, 0);
		directed[1]  = stim_row(quat_pair(16384, 0, 0, 0, 16384, 0, 0, 0), 1'b1, 0, 0, 0);
		// zero scalar part: no negation
		directed[2]  = stim_row(quat_pair(0, 16384, 0, 0, 16384, 0, 0, 0), 1'b1, 8192, 0, 0);
		directed[3]  = stim_row(quat_pair(0, 0, 16384, 0, 16384, 0, 0, 0), 1'b1, 0, 8192, 0);
		directed[4]  = stim_row(quat_pair(0, 0, 0, 16384, 16384, 0, 0, 0), 1'b1, 0, 0, 8192);
		directed[5]  = stim_row(quat_pair(16384, 0, 0, 0, 0, 16384, 0, 0), 1'b1, -8192, 0, 0);
		// negative scalar part flips the error to the short arc
		directed[6]  = stim_row(quat_pair(-1, 16384, 0, 0, 16384, 0, 0, 0), 1'b1, -8192, 0, 0);
		// tiny errors truncate toward zero in both signs
		directed[7]  = stim_row(quat_pair(16384, 1, 0, 0, 16384, 0, 0, 0), 1'b1, 0, 0, 0);
		directed[8]  = stim_row(quat_pair(16384, -1, 0, 0, 16384, 0, 0, 0), 1'b1, 0, 0, 0);
		// field extremes and non-unit quaternions
		directed[9]  = stim_row(quat_pair(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768), 1'b0, 0, 0, 0);
		directed[10] = stim_row(quat_pair(32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767), 1'b0, 0, 0, 0);
		directed[11] = stim_row(quat_pair(32767, -32768, 32767, -32768,
			-32768, 32767, -32768, 32767), 1'b0, 0, 0, 0);
		directed[12] = stim_row(quat_pair(-32768, 32767, 32767, -32768,
			32767, 32767, -32768, -32768), 1'b0, 0, 0, 0);
		directed[13] = stim_row(quat_pair(0, 32767, 32767, 32767,
			-32768, 0, 0, 0), 1'b0, 0, 0, 0);
		directed[14] = stim_row(quat_pair(16384, -16384, 16384, -16384,
			8192, 8192, 8192, 8192), 1'b0, 0, 0, 0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows under reset settings
		for (int i = 0; i < DIR_ROWS; i++)
			send_pair(directed[i].pair, directed[i].fixed, directed[i].rates);
		for (int i = 0; i < 40; i++)
			send_pair(rand_pair(), 1'b0, '0);

		// random items over a sequence of gain and limit settings
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: begin
					// all-ones data: gain bits above 16 are dropped, no clamp -> saturation
					program_axes('1, '0, '1, '0, '1, '0);
					write_reg(REG_SPARE_LO, CFG_WIDTH'($urandom));
					write_reg(REG_SPARE_HI, CFG_WIDTH'($urandom));
				end
				1: program_axes('0, '1, '0, '1, '0, '1);
				2: program_axes(CFG_WIDTH'(256), CFG_WIDTH'(1), CFG_WIDTH'(256), CFG_WIDTH'(1),
					CFG_WIDTH'(256), CFG_WIDTH'(1));
				3: program_axes('1, '1, '1, '1, '1, '1);
				default: program_axes(CFG_WIDTH'($urandom), rand_limit(),
					CFG_WIDTH'($urandom), rand_limit(), CFG_WIDTH'($urandom), rand_limit());
			endcase
			idling_on = (phase != PHASES - 1);
			count     = (phase == PHASES - 1) ? 100 : 50;
			for (int i = 0; i < count; i++)
				send_pair(rand_pair(), 1'b0, '0);
		end

		drain();
		repeat (LATENCY + 5) @(posedge clk);
		if (pending_rates.size() != 0)
			report_failure($sformatf("%0d results never arrived", pending_rates.size()));
		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
